[sv/rpb_pkg.sv]
package rpb_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [2:0] REG_BLEND_MODE   = 3'd1;
    localparam logic [2:0] REG_OPACITY      = 3'd2;
    localparam logic [2:0] REG_KEY_ENABLE   = 3'd3;
    localparam logic [2:0] REG_KEY_COLOR    = 3'd4;

    // Blend mode codes.
    localparam logic [1:0] MODE_COPY    = 2'd0;
    localparam logic [1:0] MODE_OPACITY = 2'd1;
    localparam logic [1:0] MODE_HALF    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic        RST_PIXEL_FORMAT = 1'b1;
    localparam logic [1:0]  RST_BLEND_MODE   = MODE_COPY;
    localparam logic [7:0]  RST_OPACITY      = 8'd255;
    localparam logic        RST_KEY_ENABLE   = 1'b0;
    localparam logic [15:0] RST_KEY_COLOR    = 16'h0000;

    // Masks for the half blend.
    localparam logic [15:0] HALF_MASK_555 = 16'h7bde;
    localparam logic [15:0] HALF_MASK_565 = 16'hf7de;

    localparam logic [7:0] FULL_WEIGHT = 8'd255;

    typedef struct packed {
        logic        pixel_format;
        logic [1:0]  blend_mode;
        logic [7:0]  opacity;
        logic        key_enable;
        logic [15:0] key_color;
    } cfg_t;

    // Unpacked request after the first stage.
    typedef struct packed {
        logic        keyed;
        logic        use_blend;
        logic        is565;
        logic [15:0] alt_pixel;
        logic [5:0]  src_r;
        logic [5:0]  src_g;
        logic [5:0]  src_b;
        logic [5:0]  dst_r;
        logic [5:0]  dst_g;
        logic [5:0]  dst_b;
    } unp_t;

    // Blended channels ready for packing.
    typedef struct packed {
        logic        keyed;
        logic        use_blend;
        logic        is565;
        logic [15:0] alt_pixel;
        logic [5:0]  sum_r;
        logic [5:0]  sum_g;
        logic [5:0]  sum_b;
    } sum_t;

    // Exact floor(x / 255) for x up to 63 * 255.
    function automatic logic [5:0] div255(input logic [13:0] x);
        logic [14:0] t;
        begin
            t = {1'b0, x} + 15'd1 + {9'd0, x[13:8]};
            return t[13:8];
        end
    endfunction

endpackage

[sv/rpb_cfg_regs.sv]
module rpb_cfg_regs
    import rpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave every register alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_wdata[0];
                REG_BLEND_MODE:   cfg_next.blend_mode   = cfg_wdata[1:0];
                REG_OPACITY:      cfg_next.opacity      = cfg_wdata[7:0];
                REG_KEY_ENABLE:   cfg_next.key_enable   = cfg_wdata[0];
                REG_KEY_COLOR:    cfg_next.key_color    = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_format <= RST_PIXEL_FORMAT;
            cfg_reg.blend_mode   <= RST_BLEND_MODE;
            cfg_reg.opacity      <= RST_OPACITY;
            cfg_reg.key_enable   <= RST_KEY_ENABLE;
            cfg_reg.key_color    <= RST_KEY_COLOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/rpb_unpack.sv]
module rpb_unpack
    import rpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] src_pixel,
    input  logic [15:0] dst_pixel,
    output logic        unp_valid,
    input  logic        unp_ready,
    output unp_t        unp
);

    logic        valid_reg;
    unp_t        unp_reg;
    unp_t        unp_next;
    logic        load;
    logic        key_hit;
    logic        is565;
    logic [15:0] half_mask;
    logic [15:0] half_pixel;

    assign in_ready = !valid_reg || unp_ready;
    assign load     = in_valid && in_ready;

    // Key test, half blend and channel split of one request.
    always_comb
    begin
        is565      = cfg.pixel_format;
        key_hit    = cfg.key_enable && (src_pixel == cfg.key_color);
        half_mask  = is565 ? HALF_MASK_565 : HALF_MASK_555;
        half_pixel = ((src_pixel & half_mask) >> 1) + ((dst_pixel & half_mask) >> 1);

        unp_next.keyed     = key_hit;
        unp_next.use_blend = !key_hit && (cfg.blend_mode == MODE_OPACITY);
        unp_next.is565     = is565;
        if (key_hit)
        begin
            unp_next.alt_pixel = dst_pixel;
        end
        else if (cfg.blend_mode == MODE_HALF)
        begin
            unp_next.alt_pixel = half_pixel;
        end
        else
        begin
            unp_next.alt_pixel = src_pixel;
        end

        if (is565)
        begin
            unp_next.src_r = {1'b0, src_pixel[15:11]};
            unp_next.src_g = src_pixel[10:5];
            unp_next.dst_r = {1'b0, dst_pixel[15:11]};
            unp_next.dst_g = dst_pixel[10:5];
        end
        else
        begin
            unp_next.src_r = {1'b0, src_pixel[14:10]};
            unp_next.src_g = {1'b0, src_pixel[9:5]};
            unp_next.dst_r = {1'b0, dst_pixel[14:10]};
            unp_next.dst_g = {1'b0, dst_pixel[9:5]};
        end
        unp_next.src_b = {1'b0, src_pixel[4:0]};
        unp_next.dst_b = {1'b0, dst_pixel[4:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unp_reg <= unp_next;
        end
    end

    assign unp_valid = valid_reg;
    assign unp       = unp_reg;

endmodule

[sv/rpb_scale.sv]
module rpb_scale
    import rpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] opacity,
    input  logic       unp_valid,
    output logic       unp_ready,
    input  unp_t       unp,
    output logic       sum_valid,
    input  logic       sum_ready,
    output sum_t       sum
);

    // Multiply stage registers.
    logic        mul_valid_reg;
    logic        mul_keyed_reg;
    logic        mul_use_blend_reg;
    logic        mul_is565_reg;
    logic [15:0] mul_alt_reg;
    logic [13:0] prod_sr_reg;
    logic [13:0] prod_sg_reg;
    logic [13:0] prod_sb_reg;
    logic [13:0] prod_dr_reg;
    logic [13:0] prod_dg_reg;
    logic [13:0] prod_db_reg;
    logic [13:0] w_src;
    logic [13:0] w_dst;
    logic        mul_ready;
    logic        mul_load;

    // Divide and sum stage registers.
    logic        sum_valid_reg;
    sum_t        sum_reg;
    sum_t        sum_next;
    logic        sum_load;

    assign w_src     = {6'd0, opacity};
    assign w_dst     = {6'd0, FULL_WEIGHT - opacity};

    assign sum_load  = mul_valid_reg && mul_ready;
    assign mul_ready = !sum_valid_reg || sum_ready;
    assign unp_ready = !mul_valid_reg || mul_ready;
    assign mul_load  = unp_valid && unp_ready;

    // Weight every channel of both pixels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (unp_ready)
        begin
            mul_valid_reg <= unp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_load)
        begin
            mul_keyed_reg     <= unp.keyed;
            mul_use_blend_reg <= unp.use_blend;
            mul_is565_reg     <= unp.is565;
            mul_alt_reg       <= unp.alt_pixel;
            prod_sr_reg       <= {8'd0, unp.src_r} * w_src;
            prod_sg_reg       <= {8'd0, unp.src_g} * w_src;
            prod_sb_reg       <= {8'd0, unp.src_b} * w_src;
            prod_dr_reg       <= {8'd0, unp.dst_r} * w_dst;
            prod_dg_reg       <= {8'd0, unp.dst_g} * w_dst;
            prod_db_reg       <= {8'd0, unp.dst_b} * w_dst;
        end
    end

    // Divide by 255 and add; the two weights sum to 255, so no channel overflows.
    always_comb
    begin
        sum_next.keyed     = mul_keyed_reg;
        sum_next.use_blend = mul_use_blend_reg;
        sum_next.is565     = mul_is565_reg;
        sum_next.alt_pixel = mul_alt_reg;
        sum_next.sum_r     = div255(prod_sr_reg) + div255(prod_dr_reg);
        sum_next.sum_g     = div255(prod_sg_reg) + div255(prod_dg_reg);
        sum_next.sum_b     = div255(prod_sb_reg) + div255(prod_db_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (mul_ready)
        begin
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

[sv/rgb16_pixel_blend.sv]
// Four-stage pipeline: unpack and key test, channel multiply, divide by 255
// and sum, then pack into the output register.
// Throughput is one pixel per cycle while the output is not stalled; a stall holds every full stage.
// rst_n clears all valid bits and loads the register reset values: RGB565,
// copy mode, opacity 255, color key off, key color zero.
module rgb16_pixel_blend
    import rpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] src_pixel,
    input  logic [15:0] dst_pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_pixel,
    output logic        keyed_out
);

    cfg_t        cfg;
    logic        unp_valid;
    logic        unp_ready;
    unp_t        unp;
    logic        sum_valid;
    logic        sum_ready;
    sum_t        sum;
    logic        out_valid_reg;
    logic [15:0] out_pixel_reg;
    logic [15:0] out_pixel_next;
    logic        keyed_reg;
    logic [15:0] blend_pixel;

    rpb_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rpb_unpack u_unpack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .src_pixel (src_pixel),
        .dst_pixel (dst_pixel),
        .unp_valid (unp_valid),
        .unp_ready (unp_ready),
        .unp       (unp)
    );

    rpb_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .opacity   (cfg.opacity),
        .unp_valid (unp_valid),
        .unp_ready (unp_ready),
        .unp       (unp),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum)
    );

    assign sum_ready = !out_valid_reg || out_ready;

    // Pack the blended channels; bit 15 stays zero in RGB555.
    always_comb
    begin
        if (sum.is565)
        begin
            blend_pixel = {sum.sum_r[4:0], sum.sum_g, sum.sum_b[4:0]};
        end
        else
        begin
            blend_pixel = {1'b0, sum.sum_r[4:0], sum.sum_g[4:0], sum.sum_b[4:0]};
        end
        out_pixel_next = sum.use_blend ? blend_pixel : sum.alt_pixel;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sum_ready)
        begin
            out_valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid && sum_ready)
        begin
            out_pixel_reg <= out_pixel_next;
            keyed_reg     <= sum.keyed;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign keyed_out = keyed_reg;

endmodule

[sv/rpb_checker.sv]
module rpb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_pixel,
    input logic        keyed_out
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(keyed_out))
        else $error("result changed while stalled");

    // The pipeline only refuses a request when it is full behind a stalled output.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused while the pipeline has room");

    // Drained cycles without new requests empty every stage.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_acc && out_ready) && $past(!in_acc && out_ready, 1)
        && $past(!in_acc && out_ready, 2) && $past(!in_acc && out_ready, 3)
        |=> !out_valid)
        else $error("result appeared without a request");

endmodule

bind rgb16_pixel_blend rpb_checker u_rpb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pixel (out_pixel),
    .keyed_out (keyed_out)
);
